// ===== rtl/astm_pkg.sv =====
// shared types and constants for the scaled trimmed-mean filter
// no dependencies; imported by every module of the block
package astm_pkg;

    localparam int CHAN_W     = 3;   // channel number
    localparam int SAMPLE_W   = 12;  // raw conversion code
    localparam int VAL_W      = 15;  // scaled or raw sample value, signed
    localparam int CFG_W      = 8;   // widest configuration register
    localparam int CNT_CFG_W  = 5;   // sample_count register
    localparam int IDX_CFG_W  = 1;   // configuration register index
    localparam int IN_W       = 16;  // input tdata, whole bytes
    localparam int OUT_W      = 24;  // output tdata, whole bytes

    // bipolar scaling: 10000 * m, m up to 2048, fits 25 bits
    localparam int PROD_W     = 25;
    localparam int MUL_STEPS  = SAMPLE_W;
    localparam logic [PROD_W-1:0] SCALE_K = PROD_W'(10000);

    // divisor of the serial divider
    localparam int DVS_W      = 12;
    localparam logic [DVS_W-1:0] DIV_POS = DVS_W'(2047);
    localparam logic [DVS_W-1:0] DIV_NEG = DVS_W'(2048);

    localparam int MIN_GROUP  = 3;

    localparam logic [IDX_CFG_W-1:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [IDX_CFG_W-1:0] REG_BIPOLAR_MASK = 1'b1;

    localparam logic [CNT_CFG_W-1:0] SAMPLE_COUNT_RST = 5'd3;
    localparam logic [CFG_W-1:0]     BIPOLAR_MASK_RST = 8'd24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SDIV,
        ST_ACC,
        ST_DIFF,
        ST_MSTART,
        ST_MDIV,
        ST_EMIT
    } astm_state_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } astm_stat_t;

endpackage

// ===== rtl/astm_mul.sv =====
// bit-serial multiplier by the fixed scale factor, one operand bit per cycle
// depends on astm_pkg
module astm_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [astm_pkg::SAMPLE_W-1:0]  operand,
    output astm_pkg::astm_stat_t           stat,
    output logic [astm_pkg::PROD_W-1:0]    product
);
    import astm_pkg::*;

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] m_reg, m_next;
    logic [PROD_W-1:0]   p_reg, p_next;
    logic                last;

    assign last = (cnt_reg == CNT_W'(MUL_STEPS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            m_next    = operand;
            p_next    = '0;
        end
        else if (busy_reg)
        begin
            // msb first: shift product, add factor for a set bit
            p_next   = {p_reg[PROD_W-2:0], 1'b0} + (m_reg[SAMPLE_W-1] ? SCALE_K : '0);
            m_next   = {m_reg[SAMPLE_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        p_reg <= p_next;
    end

    assign stat    = '{busy: busy_reg, done: done_reg};
    assign product = p_reg;

endmodule

// ===== rtl/astm_div.sv =====
// restoring bit-serial divider, one quotient bit per cycle, unsigned
// depends on astm_pkg
module astm_div #(
    parameter int DIV_W = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DIV_W-1:0]             dividend,
    input  logic [astm_pkg::DVS_W-1:0]   divisor,
    output astm_pkg::astm_stat_t         stat,
    output logic [DIV_W-1:0]             quotient
);
    import astm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   dd_reg, dd_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [DVS_W:0]     trial;
    logic [DVS_W:0]     diff;
    logic               ge;

    // partial remainder with the next dividend bit brought down
    assign trial = {rem_reg, dd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dd_next   = dd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dd_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            // quotient bits fill in from the bottom as dividend bits leave the top
            dd_next  = {dd_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dd_reg  <= dd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat     = '{busy: busy_reg, done: done_reg};
    assign quotient = dd_reg;

endmodule

// ===== rtl/adc_scaled_trimmed_mean.sv =====
// scaled trimmed-mean filter for 12-bit converter samples: top level
// a raw channel item goes straight to accumulation; a bipolar item is scaled first
//   (12-step serial multiplier, then 25-step serial divider for the scale)
// a group's last item then goes through the mean division on the same divider
// one item at a time; the next item is taken when the previous one is done
// reset (async, active low): empty group, no result, sample_count 3, mask 0x18
module adc_scaled_trimmed_mean #(
    parameter int MAX_GROUP = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [astm_pkg::IN_W-1:0]    s_tdata,   // channel[2:0], raw_sample[14:3]
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [astm_pkg::OUT_W-1:0]   m_tdata,   // filtered_value[14:0], result_channel[17:15]
    // configuration writes
    input  logic                         cfg_we,
    input  logic [astm_pkg::IDX_CFG_W-1:0] cfg_index,
    input  logic [astm_pkg::CFG_W-1:0]   cfg_wdata
);
    import astm_pkg::*;

    // group index counts up to MAX_GROUP-1
    localparam int IDX_W  = $clog2(MAX_GROUP);
    // wide enough for both the saturated count and the register value
    localparam int NC_RAW = $clog2(MAX_GROUP + 1);
    localparam int NC_W   = (NC_RAW > CNT_CFG_W) ? NC_RAW : CNT_CFG_W;
    // running sum of up to MAX_GROUP values of magnitude up to 10000
    localparam int SUM_W  = VAL_W + $clog2(MAX_GROUP);
    // divider covers both the scale product and the trimmed sum
    localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

    // input fields
    logic [CHAN_W-1:0]   in_channel;
    logic [SAMPLE_W-1:0] in_raw;
    logic                accept;

    assign in_channel = s_tdata[CHAN_W-1:0];
    assign in_raw     = s_tdata[CHAN_W +: SAMPLE_W];
    assign accept     = s_tvalid && s_tready;

    // configuration registers
    logic [CNT_CFG_W-1:0] sample_count_reg;
    logic [CFG_W-1:0]     bipolar_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            bipolar_mask_reg <= BIPOLAR_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[CNT_CFG_W-1:0];
                REG_BIPOLAR_MASK: bipolar_mask_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // effective group size, saturated to 3..MAX_GROUP
    logic [NC_W-1:0] sc_ext;
    logic [NC_W-1:0] grp_n;

    assign sc_ext = NC_W'(sample_count_reg);
    always_comb
    begin
        if (sc_ext < NC_W'(MIN_GROUP))
            grp_n = NC_W'(MIN_GROUP);
        else if (sc_ext > NC_W'(MAX_GROUP))
            grp_n = NC_W'(MAX_GROUP);
        else
            grp_n = sc_ext;
    end

    // serial units
    logic                 mul_start;
    logic [SAMPLE_W-1:0]  mul_operand;
    astm_stat_t           mul_stat;
    logic [PROD_W-1:0]    mul_product;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DVS_W-1:0]     div_divisor;
    astm_stat_t           div_stat;
    logic [DIV_W-1:0]     div_quotient;

    astm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .stat    (mul_stat),
        .product (mul_product)
    );

    astm_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // control and datapath registers
    astm_state_t              state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    logic [CHAN_W-1:0]        chan_reg, chan_next;
    logic                     neg_reg, neg_next;          // upper half of the code range
    logic signed [VAL_W-1:0]  val_reg, val_next;          // sample after scaling, or the raw code
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [VAL_W-1:0]  max_reg, max_next;
    logic signed [VAL_W-1:0]  min_reg, min_next;
    logic signed [SUM_W-1:0]  diff_reg, diff_next;        // sum less max and min
    logic signed [VAL_W-1:0]  mean_reg, mean_next;
    logic [VAL_W-1:0]         out_val_reg, out_val_next;
    logic [CHAN_W-1:0]        out_chan_reg, out_chan_next;

    // helpers
    logic signed [SUM_W-1:0]  val_ext;
    logic                     first;
    logic                     grp_end;
    logic [SUM_W-1:0]         diff_mag;
    logic [VAL_W-1:0]         quot_lo;

    assign val_ext  = SUM_W'(val_reg);
    assign first    = (idx_reg == '0);
    assign grp_end  = ((NC_W'(idx_reg) + NC_W'(1)) >= grp_n);
    assign diff_mag = diff_reg[SUM_W-1] ? (SUM_W'(0) - diff_reg) : diff_reg;
    assign quot_lo  = div_quotient[VAL_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        chan_next     = chan_reg;
        neg_next      = neg_reg;
        val_next      = val_reg;
        sum_next      = sum_reg;
        max_next      = max_reg;
        min_next      = min_reg;
        diff_next     = diff_reg;
        mean_next     = mean_reg;
        out_val_next  = out_val_reg;
        out_chan_next = out_chan_reg;
        mul_start     = 1'b0;
        // two's complement of the code is 4096 - x for the upper half
        mul_operand   = in_raw[SAMPLE_W-1] ? (~in_raw + SAMPLE_W'(1)) : in_raw;
        div_start     = 1'b0;
        div_dividend  = DIV_W'(mul_product);
        div_divisor   = neg_reg ? DIV_NEG : DIV_POS;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    chan_next = in_channel;
                    neg_next  = in_raw[SAMPLE_W-1];
                    if (bipolar_mask_reg[in_channel])
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        // raw code goes straight in
                        val_next   = VAL_W'(in_raw);
                        state_next = ST_ACC;
                    end
                end
            end

            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    // divide 10000*m by 2047 or 2048
                    div_start  = 1'b1;
                    state_next = ST_SDIV;
                end
            end

            ST_SDIV:
            begin
                if (div_stat.done)
                begin
                    // magnitude divided, so sign after gives truncation toward zero
                    val_next   = neg_reg ? (VAL_W'(0) - quot_lo) : quot_lo;
                    state_next = ST_ACC;
                end
            end

            ST_ACC:
            begin
                if (first)
                begin
                    // first item of a group seeds sum, max and min
                    sum_next = val_ext;
                    max_next = val_reg;
                    min_next = val_reg;
                end
                else
                begin
                    sum_next = sum_reg + val_ext;
                    if (val_reg > max_reg)
                        max_next = val_reg;
                    if (val_reg < min_reg)
                        min_next = val_reg;
                end
                if (grp_end)
                begin
                    idx_next   = '0;
                    state_next = ST_DIFF;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_IDLE;
                end
            end

            ST_DIFF:
            begin
                diff_next  = sum_reg - SUM_W'(max_reg) - SUM_W'(min_reg);
                state_next = ST_MSTART;
            end

            ST_MSTART:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(diff_mag);
                div_divisor  = DVS_W'(grp_n) - DVS_W'(2);
                state_next   = ST_MDIV;
            end

            ST_MDIV:
            begin
                if (div_stat.done)
                begin
                    mean_next  = diff_reg[SUM_W-1] ? (VAL_W'(0) - quot_lo) : quot_lo;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready)
                begin
                    out_val_next  = mean_reg;
                    out_chan_next = chan_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            sum_reg      <= '0;
            max_reg      <= '0;
            min_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            sum_reg      <= sum_next;
            max_reg      <= max_next;
            min_reg      <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg     <= chan_next;
        neg_reg      <= neg_next;
        val_reg      <= val_next;
        diff_reg     <= diff_next;
        mean_reg     <= mean_next;
        out_val_reg  <= out_val_next;
        out_chan_reg <= out_chan_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W - VAL_W - CHAN_W){1'b0}}, out_chan_reg, out_val_reg};

    // an item is only taken with both serial units at rest
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!mul_stat.busy && !div_stat.busy))
        else $error("item taken while a serial unit is busy");

    // closing a group rewinds the index
    a_group_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && grp_end) |=> (idx_reg == '0))
        else $error("group index not cleared at end of group");

    // within a group the maximum never falls below the minimum
    a_max_min: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (max_reg >= min_reg))
        else $error("running max below running min");

    // a new result only comes out of the emit state
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit state");

endmodule

// ===== test/astm_checker.sv =====
`timescale 1ns / 1ps
// checker for the scaled trimmed-mean filter: watches the sample, result and register ports
// predicts each group mean itself and compares every result item; needs astm_pkg only
module astm_checker
    import astm_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // channel[2:0], raw_sample[14:3]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,   // filtered_value[14:0], result_channel[17:15]
    input  logic                 cfg_we,
    input  logic [IDX_CFG_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   pending,
    output int                   errors
);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [CHAN_W-1:0]       chan;
    } group_mean_t;

    group_mean_t expected_means[$];

    // own copy of the registers and the group state
    logic [CNT_CFG_W-1:0] count_reg;
    logic [CFG_W-1:0]     mask_reg;
    int unsigned          taken;
    int                   run_sum;
    int                   run_max;
    int                   run_min;

    // bipolar channels map the code onto -10000..10000, others pass the raw code
    function automatic int scale_code(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] code,
                                      logic [CFG_W-1:0] mask);
        int x;
        x = int'(code);
        if (!mask[ch])
            return x;
        if (x < 2048)
            return (10000 * x) / 2047;
        return (10000 * (x - 4096)) / 2048;
    endfunction

    // register value saturated into 3..MAX_GROUP
    function automatic int group_len(logic [CNT_CFG_W-1:0] c);
        int n;
        n = int'(c);
        if (n < MIN_GROUP)
            n = MIN_GROUP;
        if (n > MAX_GROUP)
            n = MAX_GROUP;
        return n;
    endfunction

    task automatic take_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] code);
        int          v;
        int          n;
        int          mean;
        group_mean_t e;
        v = scale_code(ch, code, mask_reg);
        n = group_len(count_reg);
        if (taken == 0)
        begin
            run_sum = v;
            run_max = v;
            run_min = v;
        end
        else
        begin
            if (v > run_max)
                run_max = v;
            if (v < run_min)
                run_min = v;
            run_sum += v;
        end
        // a shrunk group size ends the group at once, even past its new length
        if (taken + 1 < n)
        begin
            taken = (taken + 1) & 31;
        end
        else
        begin
            mean = (run_sum - run_max - run_min) / (n - 2);
            e.value = VAL_W'(mean);
            e.chan  = ch;
            expected_means.push_back(e);
            taken = 0;
        end
    endtask

    task automatic check_mean(logic [OUT_W-1:0] data);
        group_mean_t e;
        logic signed [VAL_W-1:0] got_val;
        logic [CHAN_W-1:0]       got_ch;
        got_val = data[VAL_W-1:0];
        got_ch  = data[VAL_W+CHAN_W-1:VAL_W];
        if (expected_means.size() == 0)
        begin
            if (errors < 10)
                $display("%0t: unexpected result item value %0d channel %0d",
                         $realtime, got_val, got_ch);
            errors++;
        end
        else
        begin
            e = expected_means.pop_front();
            if (got_val !== e.value || got_ch !== e.chan)
            begin
                if (errors < 10)
                    $display("%0t: mismatch: expected value %0d channel %0d, got %0d channel %0d",
                             $realtime, e.value, e.chan, got_val, got_ch);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg = SAMPLE_COUNT_RST;
            mask_reg  = BIPOLAR_MASK_RST;
            taken     = 0;
            run_sum   = 0;
            run_max   = 0;
            run_min   = 0;
            expected_means.delete();
            pending   = 0;
            errors    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_mean(m_tdata);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLE_COUNT: count_reg = cfg_wdata[CNT_CFG_W-1:0];
                    REG_BIPOLAR_MASK: mask_reg  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_sample(s_tdata[CHAN_W-1:0], s_tdata[CHAN_W+SAMPLE_W-1:CHAN_W]);
            pending = expected_means.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top for adc_scaled_trimmed_mean: clock, reset, sample stimulus and verdict
// depends on astm_pkg, the block itself and astm_checker
module tb_top;
    import astm_pkg::*;

    localparam int N_ITEMS     = 1550;  // keep sending samples until at least this many
    localparam int CALM_ITEMS  = 1400;  // past this count nobody idles
    localparam int LAT_WAIT    = 100;   // settle wait: worst item's scaling plus the mean division, with margin
    localparam int HOLD_CYCLES = 1000;  // long receiver hold-off
    // longest correct quiet stretch is the hold-off plus one item's latency
    // or the settle wait between phases; this is many times over either
    localparam int STALL_LIMIT = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;   // channel[2:0], raw_sample[14:3]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // filtered_value[14:0], result_channel[17:15]
    logic                 cfg_we    = 1'b0;
    logic [IDX_CFG_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int pending;
    int errors;
    int items_sent = 0;
    int gap_pct    = 30;
    int quiet_cycles = 0;
    bit calm       = 1'b0;
    bit hold_req   = 1'b0;

    adc_scaled_trimmed_mean #(
        .MAX_GROUP(16)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    astm_checker #(
        .MAX_GROUP(16)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .pending  (pending),
        .errors   (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall bursts, ready stretches, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    // offer one sample; entered and left at a falling edge
    task automatic send_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] code);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-CHAN_W-SAMPLE_W){1'b0}}, code, ch};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // drain every expected mean, then let a result-less item finish too
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LAT_WAIT) @(negedge clk);
    endtask

    // both registers back to back; unused upper bits of the count carry junk
    task automatic write_regs(logic [CNT_CFG_W-1:0] count, logic [CFG_W-1:0] mask);
        logic [CFG_W-CNT_CFG_W-1:0] junk;
        junk = (CFG_W-CNT_CFG_W)'($urandom_range(0, 7));
        cfg_we    <= 1'b1;
        cfg_index <= REG_SAMPLE_COUNT;
        cfg_wdata <= {junk, count};
        @(negedge clk);
        cfg_index <= REG_BIPOLAR_MASK;
        cfg_wdata <= mask;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // codes lean towards the ends and the bipolar sign boundary
    function automatic logic [SAMPLE_W-1:0] pick_code();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'd2047;
            3:       return 12'd2048;
            4:       return SAMPLE_W'($urandom_range(2040, 2056));
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    initial
    begin
        int phase;
        int n_items;
        int pick;
        logic [CNT_CFG_W-1:0] count;
        logic [CFG_W-1:0]     mask;

        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: groups of three, channels 3 and 4 bipolar
        send_sample(3'd3, 12'd0);
        send_sample(3'd3, 12'd2047);
        send_sample(3'd4, 12'd2048);
        // mixed channels within each group, raw and scaled
        send_sample(3'd4, 12'd4095);
        send_sample(3'd0, 12'd0);
        send_sample(3'd7, 12'd4095);
        send_sample(3'd2, 12'd2049);
        send_sample(3'd3, 12'd1);
        send_sample(3'd5, 12'd2047);
        settle();

        // count below the minimum saturates to three, every channel bipolar
        write_regs(5'd0, 8'hff);
        send_sample(3'd1, 12'd4095);
        send_sample(3'd6, 12'd2048);
        send_sample(3'd0, 12'd2047);
        settle();

        // count above the maximum saturates, group left open
        write_regs(5'd31, 8'h00);
        send_sample(3'd7, 12'd4095);
        send_sample(3'd0, 12'd0);
        send_sample(3'd5, 12'd1234);
        send_sample(3'd2, 12'd4095);
        send_sample(3'd3, 12'd0);
        send_sample(3'd4, 12'd2048);
        settle();

        // group size shrunk below the samples already taken: next one ends it
        write_regs(5'd2, 8'h55);
        send_sample(3'd6, 12'd100);
        settle();

        // random phases, each with its own settings
        phase = 0;
        while (items_sent < N_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       count = CNT_CFG_W'($urandom_range(0, 2));
                1:       count = CNT_CFG_W'($urandom_range(17, 31));
                2:       count = 5'd16;
                3:       count = 5'd3;
                default: count = CNT_CFG_W'($urandom_range(3, 16));
            endcase
            pick = $urandom_range(0, 5);
            case (pick)
                0:       mask = 8'h00;
                1:       mask = 8'hff;
                default: mask = CFG_W'($urandom_range(0, 255));
            endcase
            // the held-off phase uses short groups so results pile up quickly
            if (phase == 3)
                count = 5'd3;
            write_regs(count, mask);
            gap_pct = (phase == 3 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
            // one phase starts with the receiver held off so the block backs up
            if (phase == 3)
                hold_req = 1'b1;
            n_items = $urandom_range(10, 60);
            repeat (n_items)
            begin
                calm = (items_sent >= CALM_ITEMS);
                send_sample(CHAN_W'($urandom_range(0, 7)), pick_code());
            end
            settle();
            phase++;
        end

        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== adc_scaled_trimmed_mean.f =====
rtl/astm_pkg.sv
rtl/astm_mul.sv
rtl/astm_div.sv
rtl/adc_scaled_trimmed_mean.sv
test/astm_checker.sv
test/tb_top.sv
